[design/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, types and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	// Number format and loop lengths
	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int GUARD        = 20;

	// Operation codes
	localparam logic [2:0] CMD_ADD  = 3'd0;
	localparam logic [2:0] CMD_SUB  = 3'd1;
	localparam logic [2:0] CMD_MUL  = 3'd2;
	localparam logic [2:0] CMD_DIV  = 3'd3;
	localparam logic [2:0] CMD_CONJ = 3'd4;
	localparam logic [2:0] CMD_MAG  = 3'd5;
	localparam logic [2:0] CMD_ARG  = 3'd6;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	// Divider: 32 integer bits, FRAC_BITS fraction bits, one rounding bit
	localparam int DIV_BITS = 32 + FRAC_BITS + 1;
	localparam int DIV_LAT  = DIV_BITS + 1;

	// CORDIC datapath widths; prep, steps, two post stages
	localparam int XW        = 32 + GUARD + 3;
	localparam int ZW        = 34;
	localparam int CORD_LAT  = CORDIC_STEPS + 3;

	localparam logic signed [65:0] SAT_HI   = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO   = -66'sd2147483648;
	localparam logic signed [65:0] RND_HALF = 66'sd1 <<< (FRAC_BITS - 1);

	// pi in binary angle units is 2^31; pi rounded to 29 fraction bits
	localparam logic signed [ZW-1:0] BAM_PI   = ZW'(64'd2147483648);
	localparam logic signed [ZW-1:0] BAM_HALF = ZW'(64'd1073741824);
	localparam logic signed [ZW-1:0] BAM_MIN  = -BAM_PI + 34'sd1;
	localparam logic [31:0]          PI_Q29   = 32'h6487ED51;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] ar;
		logic [31:0] ai;
		logic [31:0] br;
		logic [31:0] bi;
	} op_t;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  st;
	} res_t;

	typedef struct packed {
		res_t       res;
		logic [2:0] cmd;
		logic       dz;
	} smp_t;

	typedef struct packed {
		logic [63:0] m_re;
		logic        neg_re;
		logic [63:0] m_im;
		logic        neg_im;
		logic [63:0] d;
	} divop_t;

	typedef struct packed {
		logic [63:0]         r;
		logic [DIV_BITS-1:0] n;
		logic [DIV_BITS-1:0] q;
		logic [63:0]         d;
		logic                neg;
		logic                ovf;
	} dstg_t;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [XW-1:0] y;
		logic [ZW-1:0] z;
		logic [ZW-1:0] zsp;
		logic          spec;
		logic [2:0]    cmd;
	} cstg_t;

	// Clamp to 32-bit signed; top bit flags saturation
	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		if (v > SAT_HI)
			return {1'b1, 32'h7FFFFFFF};
		else if (v < SAT_LO)
			return {1'b1, 32'h80000000};
		else
			return {1'b0, v[31:0]};
	endfunction

	// Rounded atan(2^-i) in binary angle units
	function automatic logic [31:0] atan_bam(input int i);
		case (i)
			0:  return 32'h20000000;
			1:  return 32'h12E4051E;
			2:  return 32'h09FB385B;
			3:  return 32'h051111D4;
			4:  return 32'h028B0D43;
			5:  return 32'h0145D7E1;
			6:  return 32'h00A2F61E;
			7:  return 32'h00517C55;
			8:  return 32'h0028BE53;
			9:  return 32'h00145F2F;
			10: return 32'h000A2F98;
			11: return 32'h000517CC;
			12: return 32'h00028BE6;
			13: return 32'h000145F3;
			14: return 32'h0000A2FA;
			15: return 32'h0000517D;
			16: return 32'h000028BE;
			17: return 32'h0000145F;
			18: return 32'h00000A30;
			19: return 32'h00000518;
			20: return 32'h0000028C;
			21: return 32'h00000146;
			22: return 32'h000000A3;
			23: return 32'h00000051;
			24: return 32'h00000029;
			25: return 32'h00000014;
			26: return 32'h0000000A;
			27: return 32'h00000005;
			28: return 32'h00000003;
			29: return 32'h00000001;
			30: return 32'h00000001;
			default: return 32'h00000000;
		endcase
	endfunction

	// round(2^30 / gain) for a given step count
	function automatic logic [29:0] inv_gain(input int n);
		case (n)
			9:  return 30'd652034532;
			10: return 30'd652033289;
			11: return 30'd652032978;
			12: return 30'd652032900;
			13: return 30'd652032881;
			14: return 30'd652032876;
			default: begin
				if (n <= 8)
					return 30'd652039507;
				else
					return 30'd652032874;
			end
		endcase
	endfunction

	localparam logic [29:0] INV_GAIN = inv_gain(CORDIC_STEPS);

endpackage

[design/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front
// Input register, the six operand products, and the add, subtract,
// conjugate and multiply results; prepares divider operands.
// ----------------------------------------------------------------------------
module cau_front (
	input  logic               clk,
	input  logic               en,
	input  logic [2:0]         command,
	input  logic [31:0]        a_re,
	input  logic [31:0]        a_im,
	input  logic [31:0]        b_re,
	input  logic [31:0]        b_im,
	output cau_pkg::op_t       op_s1,
	output cau_pkg::smp_t      smp_s3,
	output cau_pkg::divop_t    div_s3
);

	logic signed [63:0] p_rr_s2, p_ii_s2, p_ir_s2, p_ri_s2, p_br2_s2, p_bi2_s2;
	cau_pkg::res_t      res_s2;
	logic [2:0]         cmd_s2;
	logic               dz_s2;

	logic signed [65:0] ar66, ai66, br66, bi66;
	logic [32:0]        sr, si;
	cau_pkg::res_t      simple;

	logic signed [65:0] prr, pii, pir, pri, mre, mim, sre, sim, are, aim;
	logic [32:0]        mr, mi;
	cau_pkg::res_t      res_nxt;
	cau_pkg::divop_t    div_nxt;

	// Stage 1: capture the word
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1.cmd <= command;
			op_s1.ar  <= a_re;
			op_s1.ai  <= a_im;
			op_s1.br  <= b_re;
			op_s1.bi  <= b_im;
		end
	end

	// Stage 2 logic: short operations
	always_comb begin
		ar66 = 66'($signed(op_s1.ar));
		ai66 = 66'($signed(op_s1.ai));
		br66 = 66'($signed(op_s1.br));
		bi66 = 66'($signed(op_s1.bi));
		sr = '0;
		si = '0;
		simple = '0;
		case (op_s1.cmd)
			cau_pkg::CMD_ADD: begin
				sr = cau_pkg::sat32(ar66 + br66);
				si = cau_pkg::sat32(ai66 + bi66);
			end
			cau_pkg::CMD_SUB: begin
				sr = cau_pkg::sat32(ar66 - br66);
				si = cau_pkg::sat32(ai66 - bi66);
			end
			cau_pkg::CMD_CONJ: begin
				sr = {1'b0, op_s1.ar};
				si = cau_pkg::sat32(-ai66);
			end
			default: begin
				sr = '0;
				si = '0;
			end
		endcase
		simple.re = sr[31:0];
		simple.im = si[31:0];
		simple.st = (sr[32] | si[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
	end

	// Stage 2: products
	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s2  <= $signed(op_s1.ar) * $signed(op_s1.br);
			p_ii_s2  <= $signed(op_s1.ai) * $signed(op_s1.bi);
			p_ir_s2  <= $signed(op_s1.ai) * $signed(op_s1.br);
			p_ri_s2  <= $signed(op_s1.ar) * $signed(op_s1.bi);
			p_br2_s2 <= $signed(op_s1.br) * $signed(op_s1.br);
			p_bi2_s2 <= $signed(op_s1.bi) * $signed(op_s1.bi);
			res_s2   <= simple;
			cmd_s2   <= op_s1.cmd;
			dz_s2    <= (op_s1.br == 32'd0) && (op_s1.bi == 32'd0);
		end
	end

	// Stage 3 logic: product rounding and divider operands
	always_comb begin
		prr = 66'(p_rr_s2);
		pii = 66'(p_ii_s2);
		pir = 66'(p_ir_s2);
		pri = 66'(p_ri_s2);
		mre = (prr - pii + cau_pkg::RND_HALF) >>> cau_pkg::FRAC_BITS;
		mim = (pri + pir + cau_pkg::RND_HALF) >>> cau_pkg::FRAC_BITS;
		mr  = cau_pkg::sat32(mre);
		mi  = cau_pkg::sat32(mim);
		res_nxt = res_s2;
		if (cmd_s2 == cau_pkg::CMD_MUL) begin
			res_nxt.re = mr[31:0];
			res_nxt.im = mi[31:0];
			res_nxt.st = (mr[32] | mi[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
		sre = prr + pii;
		sim = pir - pri;
		are = sre[65] ? -sre : sre;
		aim = sim[65] ? -sim : sim;
		div_nxt.m_re   = are[63:0];
		div_nxt.neg_re = sre[65];
		div_nxt.m_im   = aim[63:0];
		div_nxt.neg_im = sim[65];
		div_nxt.d      = $unsigned(p_br2_s2) + $unsigned(p_bi2_s2);
	end

	// Stage 3
	always_ff @(posedge clk) begin
		if (en) begin
			smp_s3.res <= res_nxt;
			smp_s3.cmd <= cmd_s2;
			smp_s3.dz  <= dz_s2;
			div_s3     <= div_nxt;
		end
	end

endmodule

[design/cau_div.sv]
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, one quotient bit per stage, with rounding
// to nearest (ties away from zero), sign and saturation.
// ----------------------------------------------------------------------------
module cau_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] m,
	input  logic        neg,
	input  logic [63:0] d,
	output logic [31:0] val,
	output logic        sat
);

	localparam int NB = cau_pkg::DIV_BITS;

	cau_pkg::dstg_t ent;
	cau_pkg::dstg_t div_s [NB];

	logic [49:0]        mag;
	logic signed [65:0] sv;
	logic [32:0]        sr;

	// Integer part beyond 32 bits means overflow; else start from m / 2^32
	always_comb begin
		ent.r   = {32'b0, m[63:32]};
		ent.n   = {m[31:0], {(NB - 32){1'b0}}};
		ent.q   = '0;
		ent.d   = d;
		ent.neg = neg;
		ent.ovf = ({32'b0, m[63:32]} >= d);
	end

	// One compare and subtract per stage
	for (genvar k = 0; k < NB; k++) begin : g_step
		cau_pkg::dstg_t src, nxt;
		logic [64:0]    t;

		if (k == 0) begin : g_first
			assign src = ent;
		end else begin : g_next
			assign src = div_s[k-1];
		end

		always_comb begin
			t = {src.r, src.n[NB-1]};
			nxt = src;
			nxt.n = src.n << 1;
			if (t >= {1'b0, src.d}) begin
				nxt.r = 64'(t - {1'b0, src.d});
				nxt.q = {src.q[NB-2:0], 1'b1};
			end else begin
				nxt.r = t[63:0];
				nxt.q = {src.q[NB-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en)
				div_s[k] <= nxt;
		end
	end

	// Round on the extra bit, apply sign, clamp
	always_comb begin
		mag = 50'({1'b0, div_s[NB-1].q[NB-1:1]}) + 50'(div_s[NB-1].q[0]);
		sv  = div_s[NB-1].neg ? -$signed({16'b0, mag}) : $signed({16'b0, mag});
		sr  = cau_pkg::sat32(sv);
		if (div_s[NB-1].ovf)
			sr = div_s[NB-1].neg ? {1'b1, 32'h80000000} : {1'b1, 32'h7FFFFFFF};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val <= sr[31:0];
			sat <= sr[32];
		end
	end

endmodule

[design/cau_cordic.sv]
// ----------------------------------------------------------------------------
// cau_cordic
// Unrolled CORDIC vectoring pipeline for magnitude and argument, with gain
// correction and conversion of the angle to radians.
// ----------------------------------------------------------------------------
module cau_cordic (
	input  logic          clk,
	input  logic          en,
	input  cau_pkg::op_t  op,
	output cau_pkg::res_t res
);

	localparam int N  = cau_pkg::CORDIC_STEPS;
	localparam int XW = cau_pkg::XW;
	localparam int ZW = cau_pkg::ZW;
	localparam int HW = XW - 1 - 26;

	cau_pkg::cstg_t prep;
	cau_pkg::cstg_t c_s [N+1];

	logic signed [32:0] ar33, ai33, absar, yin;
	logic               ar_zero, ai_zero, ar_neg;

	// Post stage 1 (after the last step) and post stage 2 (output)
	logic [HW+29:0] ph_s1;
	logic [55:0]    pl_s1;
	logic [63:0]    pz_s1;
	logic           negz_s1;
	logic [2:0]     cmd_s1;

	logic [XW-2:0]         mpos;
	logic signed [ZW-1:0]  zl, zc;
	logic [ZW-1:0]         az;
	logic [59:0]           t;
	logic [63:0]           r;
	logic [31:0]           rv;
	cau_pkg::res_t         res_nxt;

	// Operand preparation and argument special cases
	always_comb begin
		ar33    = {op.ar[31], op.ar};
		ai33    = {op.ai[31], op.ai};
		ar_zero = (op.ar == 32'd0);
		ai_zero = (op.ai == 32'd0);
		ar_neg  = op.ar[31];
		absar   = ar_neg ? -ar33 : ar33;
		yin     = (op.cmd == cau_pkg::CMD_ARG && ar_neg) ? -ai33 : ai33;
		prep.x  = XW'(absar) <<< cau_pkg::GUARD;
		prep.y  = XW'(yin) <<< cau_pkg::GUARD;
		prep.z  = '0;
		if (op.cmd == cau_pkg::CMD_ARG && ar_neg)
			prep.z = ai33 > 0 ? cau_pkg::BAM_PI : -cau_pkg::BAM_PI;
		prep.cmd  = op.cmd;
		prep.spec = (op.cmd == cau_pkg::CMD_ARG) && (ar_zero || (ai_zero && ar_neg));
		if (ar_zero && ai_zero)
			prep.zsp = '0;
		else if (ai_zero && ar_neg)
			prep.zsp = cau_pkg::BAM_PI;
		else
			prep.zsp = ai33 > 0 ? cau_pkg::BAM_HALF : -cau_pkg::BAM_HALF;
	end

	always_ff @(posedge clk) begin
		if (en)
			c_s[0] <= prep;
	end

	// Micro-rotations, one per stage
	for (genvar k = 0; k < N; k++) begin : g_step
		cau_pkg::cstg_t       nxt;
		logic signed [XW-1:0] xs, ys, dx, dy;
		logic signed [ZW-1:0] zs, at;

		always_comb begin
			xs  = c_s[k].x;
			ys  = c_s[k].y;
			zs  = c_s[k].z;
			dx  = ys >>> k;
			dy  = xs >>> k;
			at  = ZW'(cau_pkg::atan_bam(k));
			nxt = c_s[k];
			if (ys[XW-1]) begin
				nxt.x = xs - dx;
				nxt.y = ys + dy;
				nxt.z = zs - at;
			end else begin
				nxt.x = xs + dx;
				nxt.y = ys - dy;
				nxt.z = zs + at;
			end
		end

		always_ff @(posedge clk) begin
			if (en)
				c_s[k+1] <= nxt;
		end
	end

	// Post stage 1: gain correction products, angle clamp and scaling product
	always_comb begin
		mpos = c_s[N].x[XW-1] ? '0 : c_s[N].x[XW-2:0];
		zl   = c_s[N].z;
		zc   = zl;
		if (zl > cau_pkg::BAM_PI)
			zc = cau_pkg::BAM_PI;
		else if (zl < cau_pkg::BAM_MIN)
			zc = cau_pkg::BAM_MIN;
		if (c_s[N].spec)
			zc = c_s[N].zsp;
		az = zc[ZW-1] ? -zc : zc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1   <= mpos[XW-2:26] * cau_pkg::INV_GAIN;
			pl_s1   <= mpos[25:0] * cau_pkg::INV_GAIN;
			pz_s1   <= az[31:0] * cau_pkg::PI_Q29;
			negz_s1 <= zc[ZW-1];
			cmd_s1  <= c_s[N].cmd;
		end
	end

	// Post stage 2: round, clamp, select
	always_comb begin
		t  = 60'(ph_s1) + 60'(pl_s1 >> 26);
		t  = (t + (60'd1 << (3 + cau_pkg::GUARD))) >> (4 + cau_pkg::GUARD);
		r  = (pz_s1 + (64'd1 << (59 - cau_pkg::FRAC_BITS))) >> (60 - cau_pkg::FRAC_BITS);
		rv = negz_s1 ? 32'(-r) : r[31:0];
		res_nxt.im = '0;
		if (cmd_s1 == cau_pkg::CMD_MAG) begin
			if (|t[59:31]) begin
				res_nxt.re = 32'h7FFFFFFF;
				res_nxt.st = cau_pkg::ST_SAT;
			end else begin
				res_nxt.re = t[31:0];
				res_nxt.st = cau_pkg::ST_OK;
			end
		end else begin
			res_nxt.re = rv;
			res_nxt.st = cau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			res <= res_nxt;
	end

endmodule

[design/complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply, divide, conjugate, magnitude
// and argument on signed Q15.16 operands.
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall is low and returns one result word per
// input word, in order. The pipeline depth is set by the divider, which resolves
// one quotient bit per stage over 32 + FRAC_BITS + 1 stages; the other
// operations are delayed to line up with it. The whole pipeline freezes while a
// result is held by out_stall, and in_stall is raised for that time.
module complex_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [31:0] a_re,
	input  logic [31:0] a_im,
	input  logic [31:0] b_re,
	input  logic [31:0] b_im,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_re,
	output logic [31:0] result_im,
	output logic [1:0]  status
);

	localparam int DIV_LAT  = cau_pkg::DIV_LAT;
	localparam int CORD_DLY = cau_pkg::DIV_LAT + 2 - cau_pkg::CORD_LAT;
	localparam int PIPE_LEN = 3 + cau_pkg::DIV_LAT;

	logic            en;
	logic            out_valid_q;
	logic            vld_q [PIPE_LEN];
	cau_pkg::op_t    op_s1;
	cau_pkg::smp_t   smp_s3;
	cau_pkg::divop_t div_s3;
	cau_pkg::res_t   cord_res;
	logic [31:0]     dre_val, dim_val;
	logic            dre_sat, dim_sat;
	cau_pkg::smp_t   smp_dly_q [DIV_LAT];
	cau_pkg::res_t   cord_dly_q [CORD_DLY];
	cau_pkg::res_t   fin, res_q;

	// Pipeline advances unless a held result is stalled
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	cau_front u_front (
		.clk     (clk),
		.en      (en),
		.command (command),
		.a_re    (a_re),
		.a_im    (a_im),
		.b_re    (b_re),
		.b_im    (b_im),
		.op_s1   (op_s1),
		.smp_s3  (smp_s3),
		.div_s3  (div_s3)
	);

	cau_cordic u_cordic (
		.clk (clk),
		.en  (en),
		.op  (op_s1),
		.res (cord_res)
	);

	cau_div u_div_re (
		.clk (clk),
		.en  (en),
		.m   (div_s3.m_re),
		.neg (div_s3.neg_re),
		.d   (div_s3.d),
		.val (dre_val),
		.sat (dre_sat)
	);

	cau_div u_div_im (
		.clk (clk),
		.en  (en),
		.m   (div_s3.m_im),
		.neg (div_s3.neg_im),
		.d   (div_s3.d),
		.val (dim_val),
		.sat (dim_sat)
	);

	// Valid bits alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LEN; i++)
				vld_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < PIPE_LEN; i++)
				vld_q[i] <= vld_q[i-1];
			out_valid_q <= vld_q[PIPE_LEN-1];
		end
	end

	// Delay lines to line up with the divider output
	always_ff @(posedge clk) begin
		if (en) begin
			smp_dly_q[0] <= smp_s3;
			for (int i = 1; i < DIV_LAT; i++)
				smp_dly_q[i] <= smp_dly_q[i-1];
			cord_dly_q[0] <= cord_res;
			for (int i = 1; i < CORD_DLY; i++)
				cord_dly_q[i] <= cord_dly_q[i-1];
		end
	end

	// Result select
	always_comb begin
		fin = smp_dly_q[DIV_LAT-1].res;
		case (smp_dly_q[DIV_LAT-1].cmd)
			cau_pkg::CMD_DIV: begin
				if (smp_dly_q[DIV_LAT-1].dz) begin
					fin.re = 32'h7FFFFFFF;
					fin.im = 32'h7FFFFFFF;
					fin.st = cau_pkg::ST_DIV0;
				end else begin
					fin.re = dre_val;
					fin.im = dim_val;
					fin.st = (dre_sat | dim_sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
				end
			end
			cau_pkg::CMD_MAG, cau_pkg::CMD_ARG: fin = cord_dly_q[CORD_DLY-1];
			default: fin = smp_dly_q[DIV_LAT-1].res;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en)
			res_q <= fin;
	end

	assign out_valid = out_valid_q;
	assign result_re = res_q.re;
	assign result_im = res_q.im;
	assign status    = res_q.st;

endmodule
